/* hdl/swdc_pkg.sv */
// ----------------------------------------------------------------------------
// swdc_pkg
// Shared types and constants for the switch debouncer with double-click
// detection.
// ----------------------------------------------------------------------------
package swdc_pkg;

    localparam int EV_FIFO_DEPTH = 8;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = 1;
    localparam int Q_CNT_W       = 2;

    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_TAKE  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_PRESSED  = 2'd1;
    localparam logic [1:0] EV_RELEASED = 2'd2;
    localparam logic [1:0] EV_DOUBLE   = 2'd3;

    localparam logic [1:0] ST_NOT_STABLE    = 2'd0;
    localparam logic [1:0] ST_STABLE        = 2'd1;
    localparam logic [1:0] ST_WAIT_PRESSED  = 2'd2;
    localparam logic [1:0] ST_WAIT_RELEASED = 2'd3;

    localparam logic [1:0] KIND_LATCH_NO  = 2'd0;
    localparam logic [1:0] KIND_LATCH_NC  = 2'd1;
    localparam logic [1:0] KIND_MOMENTARY = 2'd2;
    localparam logic [1:0] KIND_SOLO      = 2'd3;

    localparam logic [1:0] CFG_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_KIND     = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd3;

    localparam logic        RST_ENABLE   = 1'b0;
    localparam logic [1:0]  RST_KIND     = KIND_MOMENTARY;
    localparam logic [15:0] RST_DEBOUNCE = 16'd20;
    localparam logic [15:0] RST_TIMEOUT  = 16'd300;

    typedef struct packed {
        logic        enable;
        logic [1:0]  kind;
        logic [15:0] debounce_ms;
        logic [15:0] timeout_ms;
    } cfg_t;

    // classified item: at most one of the class bits is set
    typedef struct packed {
        logic        poll;
        logic        pop;
        logic        take;
        logic        clear;
        logic        lvl;
        logic [31:0] now_ms;
    } item_t;

endpackage

/* hdl/swdc_ram.sv */
// ----------------------------------------------------------------------------
// swdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swdc_ram #(
    parameter int WIDTH  = 2,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/swdc_front.sv */
// ----------------------------------------------------------------------------
// swdc_front
// Input side: takes items, applies the switch-kind inversion and decodes the
// opcode into item classes for the queue (at most one set; poll needs enable).
// ----------------------------------------------------------------------------
module swdc_front import swdc_pkg::*; (
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic        raw_level,
    input  logic [31:0] now_ms,
    input  cfg_t        cfg,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    always_comb
    begin
        in_stall      = q_full;
        q_push        = in_valid && !q_full;
        q_item.poll   = (opcode == OP_POLL) && cfg.enable;
        q_item.pop    = (opcode == OP_POP);
        q_item.take   = (opcode == OP_TAKE);
        q_item.clear  = (opcode == OP_CLEAR);
        q_item.lvl    = (cfg.kind == KIND_LATCH_NC) ? raw_level : !raw_level;
        q_item.now_ms = now_ms;
    end

endmodule

/* hdl/swdc_queue.sv */
// ----------------------------------------------------------------------------
// swdc_queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
module swdc_queue import swdc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/swdc_back.sv */
// ----------------------------------------------------------------------------
// swdc_back
// Execution side: debounce state machine, duration timers, event FIFO and
// the result register.
// ----------------------------------------------------------------------------
module swdc_back import swdc_pkg::*; #(
    parameter int FIFO_DEPTH = EV_FIFO_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cfg_t                              cfg,
    input  logic                              q_valid,
    input  item_t                             q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        event_code,
    output logic                              double_flag,
    output logic                              pressed_level,
    output logic                              stable_level,
    output logic [31:0]                       pressed_duration_ms,
    output logic [31:0]                       released_duration_ms,
    output logic [$clog2(FIFO_DEPTH + 1)-1:0] queued_count
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [1:0]       state_reg,         state_next;
    logic             prev_reg,          prev_next;
    logic             deb_reg,           deb_next;
    logic [31:0]      change_time_reg,   change_time_next;
    logic [31:0]      press_start_reg,   press_start_next;
    logic [31:0]      release_start_reg, release_start_next;
    logic [31:0]      press_total_reg,   press_total_next;
    logic [31:0]      release_total_reg, release_total_next;
    logic             click_reg,         click_next;
    logic             pending_reg,       pending_next;
    logic [PTR_W-1:0] rd_ptr_reg,        rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg,        wr_ptr_next;
    logic [CNT_W-1:0] count_reg,         count_next;
    logic             out_valid_reg,     out_valid_next;
    logic             pop_hit_reg,       pop_hit_next;
    logic             flag_reg,          flag_next;

    logic             advance;
    logic             changed;
    logic [31:0]      d_change;
    logic [31:0]      d_press;
    logic [31:0]      d_release;
    logic             push;
    logic [1:0]       push_code;
    logic             ram_we;
    logic             ram_re;
    logic [1:0]       ram_rdata;

    assign advance   = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = advance;
    assign changed   = (q_item.lvl != prev_reg);
    assign d_change  = q_item.now_ms - change_time_reg;
    assign d_press   = q_item.now_ms - press_start_reg;
    assign d_release = q_item.now_ms - release_start_reg;

    always_comb
    begin
        state_next         = state_reg;
        prev_next          = prev_reg;
        deb_next           = deb_reg;
        change_time_next   = change_time_reg;
        press_start_next   = press_start_reg;
        release_start_next = release_start_reg;
        press_total_next   = press_total_reg;
        release_total_next = release_total_reg;
        click_next         = click_reg;
        pending_next       = pending_reg;
        rd_ptr_next        = rd_ptr_reg;
        wr_ptr_next        = wr_ptr_reg;
        count_next         = count_reg;
        out_valid_next     = out_valid_reg && out_stall;
        pop_hit_next       = pop_hit_reg;
        flag_next          = flag_reg;
        push               = 1'b0;
        push_code          = EV_NONE;
        ram_we             = 1'b0;
        ram_re             = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b1;
            pop_hit_next   = 1'b0;
            flag_next      = 1'b0;

            if (q_item.poll)
            begin
                prev_next = q_item.lvl;
                case (state_reg)
                    ST_NOT_STABLE:
                    begin
                        if (changed)
                        begin
                            change_time_next = q_item.now_ms;
                        end
                        else if (deb_reg != q_item.lvl)
                        begin
                            if (d_change >= {16'd0, cfg.debounce_ms})
                            begin
                                deb_next   = q_item.lvl;
                                state_next = ST_STABLE;
                            end
                        end
                        else if (deb_reg)
                        begin
                            press_total_next = d_press;
                        end
                        else
                        begin
                            release_total_next = d_release;
                        end
                    end
                    ST_STABLE:
                    begin
                        if (deb_reg)
                        begin
                            press_total_next = '0;
                            press_start_next = q_item.now_ms;
                            state_next       = ST_WAIT_PRESSED;
                        end
                        else
                        begin
                            release_total_next = '0;
                            release_start_next = q_item.now_ms;
                            state_next         = ST_WAIT_RELEASED;
                        end
                    end
                    ST_WAIT_PRESSED:
                    begin
                        press_total_next = d_press;
                        if (d_press > {16'd0, cfg.timeout_ms})
                        begin
                            push         = 1'b1;
                            push_code    = EV_PRESSED;
                            click_next   = 1'b0;
                            pending_next = 1'b0;
                            state_next   = ST_NOT_STABLE;
                        end
                        else if (click_reg)
                        begin
                            push         = 1'b1;
                            push_code    = EV_DOUBLE;
                            click_next   = 1'b0;
                            pending_next = 1'b1;
                            state_next   = ST_NOT_STABLE;
                        end
                        else if (changed)
                        begin
                            if (cfg.kind inside {KIND_MOMENTARY, KIND_SOLO})
                            begin
                                click_next   = 1'b1;
                                pending_next = 1'b0;
                            end
                            state_next = ST_NOT_STABLE;
                        end
                    end
                    default:
                    begin
                        release_total_next = d_release;
                        if (d_release > {16'd0, cfg.timeout_ms})
                        begin
                            push         = 1'b1;
                            push_code    = EV_RELEASED;
                            click_next   = 1'b0;
                            pending_next = 1'b0;
                            state_next   = ST_NOT_STABLE;
                        end
                        else if (changed)
                        begin
                            push       = 1'b1;
                            push_code  = EV_RELEASED;
                            state_next = ST_NOT_STABLE;
                        end
                    end
                endcase
            end

            if (q_item.pop && (count_reg != '0))
            begin
                ram_re       = 1'b1;
                pop_hit_next = 1'b1;
                rd_ptr_next  = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                count_next   = count_reg - 1'b1;
            end

            if (q_item.take)
            begin
                flag_next    = pending_reg;
                pending_next = 1'b0;
            end

            if (q_item.clear)
            begin
                count_next         = '0;
                rd_ptr_next        = '0;
                wr_ptr_next        = '0;
                press_total_next   = '0;
                press_start_next   = '0;
                release_total_next = '0;
            end

            // full FIFO drops the event
            if (push && (count_reg != CNT_W'(FIFO_DEPTH)))
            begin
                ram_we      = 1'b1;
                wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                count_next  = count_reg + 1'b1;
            end
        end
    end

    swdc_ram #(
        .WIDTH  (2),
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W)
    ) u_event_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (push_code),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_NOT_STABLE;
            prev_reg          <= 1'b0;
            deb_reg           <= 1'b0;
            change_time_reg   <= '0;
            press_start_reg   <= '0;
            release_start_reg <= '0;
            press_total_reg   <= '0;
            release_total_reg <= '0;
            click_reg         <= 1'b0;
            pending_reg       <= 1'b0;
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            pop_hit_reg       <= 1'b0;
            flag_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            prev_reg          <= prev_next;
            deb_reg           <= deb_next;
            change_time_reg   <= change_time_next;
            press_start_reg   <= press_start_next;
            release_start_reg <= release_start_next;
            press_total_reg   <= press_total_next;
            release_total_reg <= release_total_next;
            click_reg         <= click_next;
            pending_reg       <= pending_next;
            rd_ptr_reg        <= rd_ptr_next;
            wr_ptr_reg        <= wr_ptr_next;
            count_reg         <= count_next;
            out_valid_reg     <= out_valid_next;
            pop_hit_reg       <= pop_hit_next;
            flag_reg          <= flag_next;
        end
    end

    // state only moves when a result is loaded, so it doubles as the result
    assign out_valid            = out_valid_reg;
    assign event_code           = pop_hit_reg ? ram_rdata : EV_NONE;
    assign double_flag          = flag_reg;
    assign pressed_level        = prev_reg;
    assign stable_level         = deb_reg;
    assign pressed_duration_ms  = press_total_reg;
    assign released_duration_ms = release_total_reg;
    assign queued_count         = count_reg;

endmodule

/* hdl/switch_debounce_double_click_top.sv */
// ----------------------------------------------------------------------------
// switch_debounce_double_click_top
// Switch debouncer with double-click detection and an event FIFO.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    opcode, raw_level, now_ms
//   out      output     out_valid / out_stall  event_code, double_flag,
//                                              pressed_level, stable_level,
//                                              pressed/released_duration_ms,
//                                              queued_count
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each taken item passes
// through the front queue, then the result register, before its result is
// presented, and a stall can hold it in either.
// A stalled output fills the two-entry queue before in_stall rises.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module switch_debounce_double_click_top import swdc_pkg::*; #(
    parameter int FIFO_DEPTH = EV_FIFO_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic                              raw_level,
    input  logic [31:0]                       now_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        event_code,
    output logic                              double_flag,
    output logic                              pressed_level,
    output logic                              stable_level,
    output logic [31:0]                       pressed_duration_ms,
    output logic [31:0]                       released_duration_ms,
    output logic [$clog2(FIFO_DEPTH + 1)-1:0] queued_count,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_full;
    logic  q_push;
    item_t q_push_item;
    logic  q_pop;
    logic  q_valid;
    item_t q_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:   cfg_next.enable      = cfg_data[0];
                CFG_KIND:     cfg_next.kind        = cfg_data[1:0];
                CFG_DEBOUNCE: cfg_next.debounce_ms = cfg_data;
                CFG_TIMEOUT:  cfg_next.timeout_ms  = cfg_data;
                default:      cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= RST_ENABLE;
            cfg_reg.kind        <= RST_KIND;
            cfg_reg.debounce_ms <= RST_DEBOUNCE;
            cfg_reg.timeout_ms  <= RST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    swdc_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .raw_level (raw_level),
        .now_ms    (now_ms),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_push_item)
    );

    swdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    swdc_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg_reg),
        .q_valid              (q_valid),
        .q_item               (q_head),
        .q_pop                (q_pop),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .event_code           (event_code),
        .double_flag          (double_flag),
        .pressed_level        (pressed_level),
        .stable_level         (stable_level),
        .pressed_duration_ms  (pressed_duration_ms),
        .released_duration_ms (released_duration_ms),
        .queued_count         (queued_count)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queued_count <= ($clog2(FIFO_DEPTH + 1))'(FIFO_DEPTH))
        else $error("event count beyond FIFO depth");

    a_full_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("queue full while result register empty");

    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_code == EV_NONE || !double_flag))
        else $error("pop and take results in one item");

endmodule
